// File: rtl/core/ffrp_pkg.sv
`default_nettype none

package ffrp_pkg;

    localparam int unsigned WIN_LEN   = 16;
    localparam int unsigned STORE_LEN = WIN_LEN - 1;
    localparam int unsigned FILL_W    = 4;

    localparam logic [7:0]  HEAD_BYTE = 8'hAA;
    localparam logic [7:0]  CMD_BYTE  = 8'h11;
    localparam logic [7:0]  TAIL_BYTE = 8'h55;
    localparam logic [5:0]  LEN_MAX   = 6'd8;

    localparam logic        KIND_BYTE  = 1'b0;
    localparam logic        KIND_FLUSH = 1'b1;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(STORE_LEN);

    // stored part of the window, oldest byte at entry 0
    typedef logic [STORE_LEN-1:0][7:0] win_t;

    typedef struct packed {
        logic        ok;
        logic [10:0] can_id;
        logic [3:0]  data_len;
        logic [63:0] payload;
    } frame_t;

endpackage

`default_nettype wire

// File: rtl/core/ffrp_check.sv
`default_nettype none

module ffrp_check (
    input  var ffrp_pkg::win_t   win,
    input  wire logic [7:0]      last_byte,
    output var ffrp_pkg::frame_t frame
);

    logic len_ok;
    logic flags_ok;
    logic id_ok;

    // id bytes 3..6 little-endian, must fit in 11 bits
    assign id_ok    = (win[6] == 8'h00) && (win[5] == 8'h00) && (win[4][7:3] == 5'b00000);
    assign len_ok   = (win[2][5:0] <= ffrp_pkg::LEN_MAX);
    assign flags_ok = (win[2][7:6] == 2'b00);

    always_comb
    begin
        frame.ok       = (win[0] == ffrp_pkg::HEAD_BYTE) && (win[1] == ffrp_pkg::CMD_BYTE)
                         && (last_byte == ffrp_pkg::TAIL_BYTE) && len_ok && flags_ok && id_ok;
        frame.can_id   = {win[4][2:0], win[3]};
        frame.data_len = win[2][3:0];
        frame.payload  = {win[14], win[13], win[12], win[11],
                          win[10], win[9], win[8], win[7]};
    end

endmodule

`default_nettype wire

// File: rtl/core/ffrp_window.sv
`default_nettype none

module ffrp_window (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic          kind,
    input  wire logic [7:0]    data_byte,
    input  wire logic          frame_ok,
    output var ffrp_pkg::win_t win,
    output var logic           full
);

    ffrp_pkg::win_t                  win_reg;
    logic [ffrp_pkg::FILL_W-1:0]     fill_reg;
    logic [ffrp_pkg::FILL_W-1:0]     fill_next;

    assign win  = win_reg;
    assign full = (fill_reg == ffrp_pkg::FILL_FULL);

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
        begin
            priority if (kind == ffrp_pkg::KIND_FLUSH)
                fill_next = '0;
            else if (!full)
                fill_next = fill_reg + 1'b1;
            else if (frame_ok)
                fill_next = '0;
            else
                fill_next = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (accept && (kind == ffrp_pkg::KIND_BYTE))
        begin
            if (!full)
                win_reg[fill_reg] <= data_byte;
            else if (!frame_ok)
            begin
                // resync: drop the oldest byte
                for (int i = 0; i < ffrp_pkg::STORE_LEN - 1; i++)
                    win_reg[i] <= win_reg[i+1];
                win_reg[ffrp_pkg::STORE_LEN-1] <= data_byte;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ffrp_out_reg.sv
`default_nettype none

module ffrp_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  var ffrp_pkg::frame_t  frame,
    input  wire logic             out_ready,
    output var logic              out_valid,
    output var logic [10:0]       can_id,
    output var logic [3:0]        data_len,
    output var logic [63:0]       payload
);

    logic        valid_reg;
    logic        valid_next;
    logic [10:0] id_reg;
    logic [3:0]  len_reg;
    logic [63:0] pay_reg;

    assign out_valid = valid_reg;
    assign can_id    = id_reg;
    assign data_len  = len_reg;
    assign payload   = pay_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            id_reg  <= frame.can_id;
            len_reg <= frame.data_len;
            pay_reg <= frame.payload;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fixed_frame_resync_parser.sv
// fixed-length frame parser with resync on a 16-byte sliding window
//
// input channel: in_valid/in_ready, one beat carries kind and data_byte;
//   kind 0 pushes data_byte into the window, kind 1 flushes the window
// output channel: out_valid/out_ready, one beat per good frame with
//   can_id, data_len and the eight payload bytes (byte 7 in bits 7:0)
// throughput: one input beat per cycle while in_ready is high; the frame check
//   is a parallel compare over the 15 stored bytes plus the incoming byte, so
//   the window is updated in the cycle that accepts the byte
// latency: the result beat is valid the cycle after the 16th byte of a
//   good frame is accepted
// stall: one output register; while it holds an untaken beat and
//   out_ready is low, in_ready is low and the window holds still
// reset: rst_n clears the fill count and the output valid; window bytes
//   are not reset, only written entries are ever looked at
`default_nettype none

module fixed_frame_resync_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output var logic         in_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  data_byte,
    output var logic         out_valid,
    input  wire logic        out_ready,
    output var logic [10:0]  can_id,
    output var logic [3:0]   data_len,
    output var logic [63:0]  payload
);

    ffrp_pkg::win_t   win;
    ffrp_pkg::frame_t frame;
    logic             full;
    logic             accept;
    logic             emit;

    // take a new beat whenever the output register is free or draining
    assign in_ready = !out_valid || out_ready;
    assign accept   = in_valid && in_ready;

    // a frame is checked only when the incoming byte completes the window
    assign emit = accept && (kind == ffrp_pkg::KIND_BYTE) && full && frame.ok;

    ffrp_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .data_byte (data_byte),
        .frame_ok  (frame.ok),
        .win       (win),
        .full      (full)
    );

    // incoming byte serves as window byte 15 (trailer)
    ffrp_check u_check (
        .win       (win),
        .last_byte (data_byte),
        .frame     (frame)
    );

    ffrp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .frame     (frame),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_id    (can_id),
        .data_len  (data_len),
        .payload   (payload)
    );

endmodule

`default_nettype wire

// File: rtl/core/ffrp_checker.sv
`default_nettype none

module ffrp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        kind,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [10:0] can_id,
    input wire logic [3:0]  data_len,
    input wire logic [63:0] payload
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(can_id)
            && $stable(data_len) && $stable(payload))
        else $error("result beat changed while stalled");

    // no new input while the output register is blocked
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // a result only follows an accepted data byte
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && !kind))
        else $error("result without a data byte");

    // reported length never exceeds eight
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> data_len <= 4'd8)
        else $error("length out of range");

endmodule

bind fixed_frame_resync_parser ffrp_checker u_ffrp_checker (.*);

`default_nettype wire
